[src/ddf_pkg.sv]
// ----------------------------------------------------------------------------
// ddf_pkg: shared types and constants of the decimal display formatter
// Item structs, the context carried down the digit cells and the ASCII codes.
// ----------------------------------------------------------------------------
package ddf_pkg;

    localparam int unsigned ValueW     = 16;
    localparam int unsigned PointW     = 3;
    localparam int unsigned ByteW      = 8;
    localparam int unsigned NumDigits  = 4;
    localparam int unsigned DigitW     = 4;
    localparam int unsigned RemW       = 10;
    localparam int unsigned QuotW      = 7;
    localparam int unsigned RunW       = 3;
    localparam int unsigned NumCells   = NumDigits + 2;

    // floor(v / 1000) == (v * Recip) >> RecipShift for every 16-bit v.
    localparam int unsigned Thousand   = 1000;
    localparam int unsigned Recip      = 67109;
    localparam int unsigned RecipShift = 26;
    localparam int unsigned DigitStep  = 100;
    localparam int unsigned MaxDigit   = 9;

    localparam logic [PointW-1:0] MaxPoint = 3'd4;
    localparam logic [PointW-1:0] NoPoint  = 3'd0;
    localparam logic [RunW-1:0]   RunShort = 3'd5;
    localparam logic [RunW-1:0]   RunLong  = 3'd6;

    localparam logic [ByteW-1:0] CharZero  = 8'h30;
    localparam logic [ByteW-1:0] CharPoint = 8'h2E;
    localparam logic [ByteW-1:0] CharSpace = 8'h20;

    localparam logic KindCmd  = 1'b0;
    localparam logic KindChar = 1'b1;

    typedef struct packed {
        logic [ValueW-1:0] value;
        logic [PointW-1:0] point_position;
        logic [ByteW-1:0]  cursor_command;
    } t_in_item;

    typedef struct packed {
        logic             kind;
        logic [ByteW-1:0] byte_out;
        logic             last;
    } t_out_item;

    // Digits enter at the low nibble and move up one nibble per digit cell.
    typedef struct packed {
        logic [PointW-1:0]           point;
        logic [ByteW-1:0]            cmd;
        logic [NumDigits*DigitW-1:0] digits;
    } t_ctx;

    typedef struct packed {
        logic             kind;
        logic [ByteW-1:0] data;
    } t_cell;

endpackage

[src/ddf_digit_cell.sv]
// ----------------------------------------------------------------------------
// ddf_digit_cell: one decimal digit per cell
// Takes a remainder below 1000, emits its hundreds digit and hands the
// remainder times ten to the next cell.
// ----------------------------------------------------------------------------
module ddf_digit_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [ddf_pkg::RemW-1:0]   i_x,
    input  ddf_pkg::t_ctx              i_ctx,
    output logic                       o_valid,
    output logic [ddf_pkg::RemW-1:0]   o_x,
    output ddf_pkg::t_ctx              o_ctx
);
    import ddf_pkg::*;

    logic                r_valid;
    logic [RemW-1:0]     r_x;
    t_ctx                r_ctx;

    logic [DigitW-1:0]   w_digit;
    logic [RemW-1:0]     w_sub;
    logic [RemW-1:0]     w_rem;
    logic [RemW-1:0]     n_x;
    t_ctx                n_ctx;

    always_comb begin
        w_digit = '0;
        w_sub   = '0;
        for (int m = 1; m <= MaxDigit; m++) begin
            if (i_x >= RemW'(m * DigitStep)) begin
                w_digit = DigitW'(m);
                w_sub   = RemW'(m * DigitStep);
            end
        end
        w_rem = i_x - w_sub;
        // The remainder is below 100, so times ten stays below 1000.
        n_x   = {w_rem[6:0], 3'b000} + RemW'({w_rem[6:0], 1'b0});
        n_ctx        = i_ctx;
        n_ctx.digits = {i_ctx.digits[(NumDigits-1)*DigitW-1:0], w_digit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_ctx <= n_ctx;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_ctx   = r_ctx;

endmodule

[src/ddf_byte_cell.sv]
// ----------------------------------------------------------------------------
// ddf_byte_cell: one byte of the output run
// Loads its byte of a new run, or takes its neighbor's byte when the head
// of the run has been taken.
// ----------------------------------------------------------------------------
module ddf_byte_cell (
    input  logic           i_clk,
    input  logic           i_load,
    input  logic           i_shift,
    input  ddf_pkg::t_cell i_load_data,
    input  ddf_pkg::t_cell i_next,
    output ddf_pkg::t_cell o_data
);
    import ddf_pkg::*;

    t_cell r_data;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_load_data;
        end else if (i_shift) begin
            r_data <= i_next;
        end
    end

    assign o_data = r_data;

endmodule

[src/decimal_display_formatter.sv]
// ----------------------------------------------------------------------------
// decimal_display_formatter: binary value to a framed four-digit display run
// Splits the value into ASCII digits, inserts the point, blanks leading zeros
// and sends the cursor command followed by the characters.
// ----------------------------------------------------------------------------
// Each input item produces a run of output items on the result channel: the
// cursor command, then four characters, or five when a decimal point is used;
// the last one is flagged. The row of byte cells sends one byte per cycle while
// the sink is ready, and that sets the sustained rate: with steady input and a
// ready sink the runs follow each other with no gap. Conversion runs through an
// input register, a multiply stage for the thousands, a subtract stage and a
// chain of three digit cells, and then the run is loaded into the byte cells.
// New items are taken while a run is still being sent, until the conversion
// stages are full.
module decimal_display_formatter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ddf_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output ddf_pkg::t_out_item  o_item
);
    import ddf_pkg::*;

    localparam int unsigned NumDigitCells = NumDigits - 1;

    // Pipeline advance: every conversion stage moves when the tail is free.
    logic w_adv;
    logic w_load;
    logic w_take;
    logic w_shift;

    // Input stage.
    logic              r0_valid;
    logic [ValueW-1:0] r0_v;
    logic [PointW-1:0] r0_p;
    logic [ByteW-1:0]  r0_cmd;

    // Thousands quotient stage.
    logic [ValueW+RecipShift-10:0] w_prod;
    logic              r1_valid;
    logic [ValueW-1:0] r1_v;
    logic [QuotW-1:0]  r1_q;
    logic [PointW-1:0] r1_p;
    logic [ByteW-1:0]  r1_cmd;

    // Remainder stage.
    logic [ValueW:0]   w_qk;
    logic [ValueW:0]   w_diff;
    logic [DigitW-1:0] w_d0;
    logic              r2_valid;
    logic [RemW-1:0]   r2_x;
    t_ctx              r2_ctx;

    // Digit cell chain.
    logic              w_cv [NumDigitCells+1];
    logic [RemW-1:0]   w_cx [NumDigitCells+1];
    t_ctx              w_cc [NumDigitCells+1];

    // Formatting and output run.
    t_ctx              w_tail;
    logic [PointW-1:0] w_pc;
    logic [ByteW-1:0]  w_a    [NumDigits];
    logic [ByteW-1:0]  w_seq  [NumDigits+1];
    logic              w_go;
    logic [RunW-1:0]   n_left;
    logic [RunW-1:0]   r_left;
    t_cell             w_load_data [NumCells];
    t_cell             w_cell      [NumCells];
    t_cell             w_next      [NumCells];

    assign w_take  = o_valid && i_ready;
    assign w_load  = w_cv[NumDigitCells] &&
                     ((r_left == '0) || ((r_left == RunW'(1)) && i_ready));
    assign w_shift = w_take && !w_load;
    assign w_adv   = !w_cv[NumDigitCells] || w_load;
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (w_adv) begin
            r0_valid <= i_valid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
        end
    end

    assign w_prod = (ValueW+RecipShift-9)'(r0_v) * (ValueW+RecipShift-9)'(Recip);
    assign w_qk   = (ValueW+1)'(r1_q) * (ValueW+1)'(Thousand);
    assign w_diff = (ValueW+1)'(r1_v) - w_qk;
    // Values above 9999 keep the thousands digit at nine.
    assign w_d0   = (r1_q > QuotW'(MaxDigit)) ? DigitW'(MaxDigit) : r1_q[DigitW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_v          <= i_item.value;
            r0_p          <= i_item.point_position;
            r0_cmd        <= i_item.cursor_command;
            r1_v          <= r0_v;
            r1_q          <= w_prod[RecipShift +: QuotW];
            r1_p          <= r0_p;
            r1_cmd        <= r0_cmd;
            r2_x          <= w_diff[RemW-1:0];
            r2_ctx.point  <= r1_p;
            r2_ctx.cmd    <= r1_cmd;
            r2_ctx.digits <= {{((NumDigits-1)*DigitW){1'b0}}, w_d0};
        end
    end

    assign w_cv[0] = r2_valid;
    assign w_cx[0] = r2_x;
    assign w_cc[0] = r2_ctx;

    for (genvar g = 0; g < NumDigitCells; g++) begin : g_digit
        ddf_digit_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_cv[g]),
            .i_x     (w_cx[g]),
            .i_ctx   (w_cc[g]),
            .o_valid (w_cv[g+1]),
            .o_x     (w_cx[g+1]),
            .o_ctx   (w_cc[g+1])
        );
    end

    // The last remainder is spent; only the context of the tail is needed.
    assign w_tail = (w_cx[NumDigitCells] == '0) ? w_cc[NumDigitCells]
                                                : w_cc[NumDigitCells];

    always_comb begin
        w_pc = (w_tail.point > MaxPoint) ? MaxPoint : w_tail.point;
        for (int i = 0; i < NumDigits; i++) begin
            w_a[i] = CharZero + ByteW'(w_tail.digits[(NumDigits-1-i)*DigitW +: DigitW]);
        end
        for (int i = 0; i <= NumDigits; i++) begin
            w_seq[i] = CharSpace;
        end
        case (w_pc)
            3'd1: begin
                w_seq[0] = w_a[0]; w_seq[1] = CharPoint; w_seq[2] = w_a[1];
                w_seq[3] = w_a[2]; w_seq[4] = w_a[3];
            end
            3'd2: begin
                w_seq[0] = w_a[0]; w_seq[1] = w_a[1]; w_seq[2] = CharPoint;
                w_seq[3] = w_a[2]; w_seq[4] = w_a[3];
            end
            3'd3: begin
                w_seq[0] = w_a[0]; w_seq[1] = w_a[1]; w_seq[2] = w_a[2];
                w_seq[3] = CharPoint; w_seq[4] = w_a[3];
            end
            3'd4: begin
                w_seq[0] = w_a[0]; w_seq[1] = w_a[1]; w_seq[2] = w_a[2];
                w_seq[3] = w_a[3]; w_seq[4] = CharPoint;
            end
            default: begin
                w_seq[0] = w_a[0]; w_seq[1] = w_a[1]; w_seq[2] = w_a[2];
                w_seq[3] = w_a[3];
            end
        endcase
        // Blank up to three leading zeros; a point or a nonzero digit stops it.
        w_go = 1'b1;
        for (int k = 0; k < NumDigits - 1; k++) begin
            if (w_go) begin
                if (w_seq[k] == CharZero) begin
                    w_seq[k] = CharSpace;
                end else begin
                    w_go = 1'b0;
                end
            end
        end
        n_left = (w_pc != NoPoint) ? RunLong : RunShort;
    end

    always_comb begin
        w_load_data[0].kind = KindCmd;
        w_load_data[0].data = w_tail.cmd;
        for (int i = 1; i < NumCells; i++) begin
            w_load_data[i].kind = KindChar;
            w_load_data[i].data = w_seq[i-1];
        end
        for (int i = 0; i < NumCells - 1; i++) begin
            w_next[i] = w_cell[i+1];
        end
        w_next[NumCells-1] = '0;
    end

    for (genvar g = 0; g < NumCells; g++) begin : g_byte
        ddf_byte_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (w_load),
            .i_shift     (w_shift),
            .i_load_data (w_load_data[g]),
            .i_next      (w_next[g]),
            .o_data      (w_cell[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (w_load) begin
            r_left <= n_left;
        end else if (w_take) begin
            r_left <= r_left - RunW'(1);
        end
    end

    assign o_valid         = (r_left != '0);
    assign o_item.kind     = w_cell[0].kind;
    assign o_item.byte_out = w_cell[0].data;
    assign o_item.last     = (r_left == RunW'(1));

`ifndef SYNTHESIS
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= RunLong)
        else $error("output run counter out of range");

    a_load_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_left == RunShort || r_left == RunLong))
        else $error("run length after load is not 5 or 6");

    a_cmd_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && o_item.kind == KindCmd) |=> (o_valid && o_item.kind == KindChar))
        else $error("command item not followed by a character item");

    a_last_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.last) |-> (o_item.kind == KindChar))
        else $error("last flag on a command item");

    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_item.kind == KindCmd))
        else $error("new run does not start with the command item");
`endif

endmodule
